### rtl/hcf_pkg.sv
// ----------------------------------------------------------------------------
// Hertz contact force package
// Shared types, codes and constants of the contact force unit.
// ----------------------------------------------------------------------------
package hcf_pkg;

	localparam int APB_AW = 5;
	localparam int APB_DW = 64;

	localparam logic [1:0] REG_DIMENSION = 2'd0;
	localparam logic [1:0] REG_AXISYM    = 2'd1;
	localparam logic [1:0] REG_MODULUS   = 2'd2;
	localparam logic [1:0] REG_SCREEN    = 2'd3;

	localparam logic [1:0]  RST_DIMENSION = 2'd3;
	localparam logic        RST_AXISYM    = 1'b0;
	localparam logic [47:0] RST_MODULUS   = 48'd65536;
	localparam logic [30:0] RST_SCREEN    = 31'd65536;

	localparam int ALU_XW = 128;
	localparam int ALU_BW = 64;

	typedef struct packed {
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic signed [31:0] offset_z;
		logic [31:0]        vol_a;
		logic [31:0]        vol_b;
		logic [30:0]        radial_a;
		logic [30:0]        radial_b;
		logic               first_of_step;
	} hcf_pair_t;

	typedef struct packed {
		logic               in_contact;
		logic signed [63:0] force_x;
		logic signed [63:0] force_y;
		logic signed [63:0] force_z;
		logic signed [63:0] sum_x;
		logic signed [63:0] sum_y;
		logic signed [63:0] sum_z;
	} hcf_result_t;

	typedef struct packed {
		logic [1:0]  dimension_mode;
		logic        axisymmetric_mode;
		logic [47:0] contact_modulus;
		logic [30:0] screen_distance;
	} hcf_cfg_t;

	typedef enum logic [2:0] {
		ALU_MUL,
		ALU_MAC,
		ALU_DIV,
		ALU_SQRT,
		ALU_CBRT
	} hcf_alu_op_t;

	typedef struct packed {
		logic        start;
		hcf_alu_op_t op;
	} hcf_alu_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAD_DIV,
		ST_RAD_ROOT,
		ST_SQ,
		ST_DIST,
		ST_PROD,
		ST_RRED,
		ST_RP,
		ST_SROOT,
		ST_SP,
		ST_EM,
		ST_DIV3,
		ST_UNIT,
		ST_FORCE,
		ST_DONE
	} hcf_state_t;

endpackage

### rtl/hcf_if.sv
// ----------------------------------------------------------------------------
// Hertz contact force channels
// Valid/ready channels for candidate pairs and force results.
// ----------------------------------------------------------------------------
interface hcf_pair_if;
	logic              valid;
	logic              ready;
	hcf_pkg::hcf_pair_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hcf_result_if;
	logic                valid;
	logic                ready;
	hcf_pkg::hcf_result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/hcf_regs.sv
// ----------------------------------------------------------------------------
// Hertz contact force registers
// APB-style configuration registers, one 64-bit slot per register.
// ----------------------------------------------------------------------------
module hcf_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hcf_pkg::APB_AW-1:0]   paddr,
	input  logic [hcf_pkg::APB_DW-1:0]   pwdata,
	output logic [hcf_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output hcf_pkg::hcf_cfg_t            cfg
);
	hcf_pkg::hcf_cfg_t cfg_q;
	logic [1:0]        sel;
	logic              wr;

	assign sel    = paddr[4:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dimension_mode    <= hcf_pkg::RST_DIMENSION;
			cfg_q.axisymmetric_mode <= hcf_pkg::RST_AXISYM;
			cfg_q.contact_modulus   <= hcf_pkg::RST_MODULUS;
			cfg_q.screen_distance   <= hcf_pkg::RST_SCREEN;
		end else if (wr) begin
			case (sel)
				hcf_pkg::REG_DIMENSION: cfg_q.dimension_mode    <= pwdata[1:0];
				hcf_pkg::REG_AXISYM:    cfg_q.axisymmetric_mode <= pwdata[0];
				hcf_pkg::REG_MODULUS:   cfg_q.contact_modulus   <= pwdata[47:0];
				hcf_pkg::REG_SCREEN:    cfg_q.screen_distance   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			hcf_pkg::REG_DIMENSION: prdata = {62'd0, cfg_q.dimension_mode};
			hcf_pkg::REG_AXISYM:    prdata = {63'd0, cfg_q.axisymmetric_mode};
			hcf_pkg::REG_MODULUS:   prdata = {16'd0, cfg_q.contact_modulus};
			hcf_pkg::REG_SCREEN:    prdata = {33'd0, cfg_q.screen_distance};
			default:                prdata = '0;
		endcase
	end
endmodule

### rtl/hcf_alu.sv
// ----------------------------------------------------------------------------
// Hertz contact force shared arithmetic unit
// Bit-serial multiply, divide, square root and cube root, one step a cycle.
// ----------------------------------------------------------------------------
module hcf_alu #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hcf_pkg::hcf_alu_ctrl_t     ctrl,
	input  logic [hcf_pkg::ALU_XW-1:0] opa,
	input  logic [hcf_pkg::ALU_BW-1:0] opb,
	output logic                       done,
	output logic [hcf_pkg::ALU_XW-1:0] res
);
	localparam int XW   = hcf_pkg::ALU_XW;
	localparam int DW   = 72;
	localparam int SQ_W = (2 * FRAC_BITS + 32 > 64) ? 2 * FRAC_BITS + 32 : 64;
	localparam int CB_W = 3 * ((2 * FRAC_BITS + 34) / 3);
	localparam logic [6:0] MUL_STEPS = 7'd64;
	localparam logic [6:0] DIV_STEPS = 7'(DW);
	localparam logic [6:0] SQ_STEPS  = 7'(SQ_W / 2);
	localparam logic [6:0] CB_STEPS  = 7'(CB_W / 3);

	hcf_pkg::hcf_alu_op_t op_q;
	logic                 busy_q, done_q;
	logic [6:0]           cnt_q, steps;
	logic [XW-1:0]        x_q, acc_q;
	logic [63:0]          y_q, a3_q;
	logic [31:0]          c3_q;
	logic [DW-1:0]        rem_q, cand, trial, diff;
	logic [33:0]          d_q;
	logic                 ge;

	always_comb begin
		case (ctrl.op)
			hcf_pkg::ALU_DIV:  steps = DIV_STEPS;
			hcf_pkg::ALU_SQRT: steps = SQ_STEPS;
			hcf_pkg::ALU_CBRT: steps = CB_STEPS;
			default:           steps = MUL_STEPS;
		endcase
	end

	always_comb begin
		case (op_q)
			hcf_pkg::ALU_DIV: begin
				cand  = {rem_q[DW-2:0], x_q[XW-1]};
				trial = {38'd0, d_q};
			end
			hcf_pkg::ALU_SQRT: begin
				cand  = {rem_q[DW-3:0], x_q[XW-1:XW-2]};
				trial = {6'd0, y_q, 2'b01};
			end
			hcf_pkg::ALU_CBRT: begin
				cand  = {rem_q[DW-4:0], x_q[XW-1:XW-3]};
				trial = {6'd0, a3_q, 2'b00} + {39'd0, c3_q, 1'b0} + 72'd1;
			end
			default: begin
				cand  = '0;
				trial = '0;
			end
		endcase
		ge   = cand >= trial;
		diff = cand - trial;
	end

	always_comb begin
		case (op_q)
			hcf_pkg::ALU_DIV:  res = {56'd0, x_q[DW-1:0]};
			hcf_pkg::ALU_SQRT: res = {64'd0, y_q};
			hcf_pkg::ALU_CBRT: res = {64'd0, y_q};
			default:           res = acc_q;
		endcase
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 7'd1);
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			op_q <= ctrl.op;
			case (ctrl.op)
				hcf_pkg::ALU_MUL: begin
					acc_q <= '0;
					x_q   <= opa;
					y_q   <= opb;
				end
				hcf_pkg::ALU_MAC: begin
					x_q <= opa;
					y_q <= opb;
				end
				hcf_pkg::ALU_DIV: begin
					x_q   <= opa << (XW - DW);
					d_q   <= opb[33:0];
					rem_q <= '0;
				end
				hcf_pkg::ALU_SQRT: begin
					x_q   <= opa << (XW - SQ_W);
					y_q   <= '0;
					rem_q <= '0;
				end
				hcf_pkg::ALU_CBRT: begin
					x_q   <= opa << (XW - CB_W);
					y_q   <= '0;
					rem_q <= '0;
					a3_q  <= '0;
					c3_q  <= '0;
				end
				default: ;
			endcase
		end else if (busy_q) begin
			case (op_q)
				hcf_pkg::ALU_MUL, hcf_pkg::ALU_MAC: begin
					if (y_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
				hcf_pkg::ALU_DIV: begin
					rem_q <= ge ? diff : cand;
					x_q   <= {x_q[XW-2:0], ge};
				end
				hcf_pkg::ALU_SQRT: begin
					rem_q <= ge ? diff : cand;
					y_q   <= {y_q[62:0], ge};
					x_q   <= x_q << 2;
				end
				hcf_pkg::ALU_CBRT: begin
					rem_q <= ge ? diff : cand;
					y_q   <= {y_q[62:0], ge};
					x_q   <= x_q << 3;
					if (ge) begin
						a3_q <= (a3_q << 2) + {30'd0, c3_q, 2'b00} + 64'd3;
						c3_q <= {c3_q[30:0], 1'b0} + 32'd3;
					end else begin
						a3_q <= a3_q << 2;
						c3_q <= {c3_q[30:0], 1'b0};
					end
				end
				default: ;
			endcase
		end
	end
endmodule

### rtl/hertz_contact_force_unit.sv
// Pairs are handled one at a time; the next pair is taken only after the result is registered.
// All arithmetic runs on the shared bit-serial unit: one bit of a product, quotient or
// root per cycle, for every multiply, divide and root of the force chain.
// Reset: arst_n clears the sequencer and the running totals and returns the configuration to its defaults.
// ----------------------------------------------------------------------------
// Hertz contact force unit
// Screens one particle pair and computes its Hertz force and running total.
// ----------------------------------------------------------------------------
module hertz_contact_force_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	hcf_pair_if.sink                   pair,
	hcf_result_if.source               result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hcf_pkg::APB_AW-1:0] paddr,
	input  logic [hcf_pkg::APB_DW-1:0] pwdata,
	output logic [hcf_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	localparam int EM_SH = 34 - 2 * FRAC_BITS;
	localparam int SH_L  = (EM_SH > 0) ? EM_SH : 0;
	localparam int SH_R  = (EM_SH < 0) ? -EM_SH : 0;
	localparam logic [127:0] M_LIMIT = 128'd3 << 63;
	localparam logic [62:0]  MAX63   = '1;
	localparam logic [63:0]  THIRD_RECIP = 64'hAAAA_AAAA_AAAA_AAAB;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	hcf_pkg::hcf_cfg_t     cfg;
	hcf_pkg::hcf_state_t   state_q, state_d;
	hcf_pkg::hcf_alu_ctrl_t alu_ctrl;
	hcf_pkg::hcf_result_t  out_q;
	logic [127:0]          opa, alu_res, tmp_q, q_big, m1_wide;
	logic [63:0]           opb;
	logic                  alu_done, launch_q, k_q, out_valid_q, contact_q;
	logic [1:0]            idx_q;
	logic [31:0]           mag_q [3];
	logic                  neg_q [3];
	logic [31:0]           vol_q [2];
	logic [30:0]           rad_q [2];
	logic [31:0]           radius_q [2];
	logic [31:0]           r_q, vol_sel, mag_sel;
	logic [62:0]           m_q, fm;
	logic signed [63:0]    f_q [3];
	logic signed [63:0]    tot_q [3];
	logic signed [63:0]    tot_n [3];
	logic [32:0]           rp, p;
	logic                  two_d, axis2d, box_ok, last_axis, can_out, accept;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			sat_add = a[63] ? S64_MIN : S64_MAX;
		end else begin
			sat_add = s;
		end
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] d);
		abs32 = d[31] ? (32'(~d) + 32'd1) : 32'(d);
	endfunction

	hcf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hcf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (alu_ctrl),
		.opa    (opa),
		.opb    (opb),
		.done   (alu_done),
		.res    (alu_res)
	);

	assign two_d     = cfg.dimension_mode == 2'd2;
	assign axis2d    = two_d && cfg.axisymmetric_mode;
	assign rp        = {1'b0, radius_q[0]} + {1'b0, radius_q[1]};
	assign p         = rp - {1'b0, r_q};
	assign vol_sel   = k_q ? vol_q[1] : vol_q[0];
	assign mag_sel   = mag_q[idx_q];
	assign last_axis = two_d ? (idx_q == 2'd1) : (idx_q == 2'd2);
	assign q_big     = (alu_res << SH_L) >> SH_R;
	assign m1_wide   = alu_res >> FRAC_BITS;
	assign fm        = (|alu_res[127:95]) ? MAX63 : alu_res[94:32];
	assign can_out   = !out_valid_q || result.ready;
	assign accept    = pair.valid && pair.ready;

	always_comb begin
		box_ok = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (mag_q[i] > {1'b0, cfg.screen_distance} || {1'b0, mag_q[i]} > rp) begin
				box_ok = 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot_n[i] = contact_q ? sat_add(tot_q[i], f_q[i]) : tot_q[i];
		end
	end

	assign pair.ready   = state_q == hcf_pkg::ST_IDLE;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		alu_ctrl.start = 1'b0;
		alu_ctrl.op    = hcf_pkg::ALU_MUL;
		opa            = '0;
		opb            = '0;
		case (state_q)
			hcf_pkg::ST_IDLE: begin
				if (pair.valid) begin
					state_d = axis2d ? hcf_pkg::ST_RAD_DIV : hcf_pkg::ST_RAD_ROOT;
				end
			end
			hcf_pkg::ST_RAD_DIV: begin
				alu_ctrl.op = hcf_pkg::ALU_DIV;
				opa = {96'd0, vol_sel} << FRAC_BITS;
				opb = {33'd0, k_q ? rad_q[1] : rad_q[0]};
				if (alu_done) begin
					state_d = hcf_pkg::ST_RAD_ROOT;
				end
			end
			hcf_pkg::ST_RAD_ROOT: begin
				if (axis2d) begin
					alu_ctrl.op = hcf_pkg::ALU_SQRT;
					opa = tmp_q << FRAC_BITS;
				end else if (two_d) begin
					alu_ctrl.op = hcf_pkg::ALU_SQRT;
					opa = {96'd0, vol_sel} << FRAC_BITS;
				end else begin
					alu_ctrl.op = hcf_pkg::ALU_CBRT;
					opa = {96'd0, vol_sel} << (2 * FRAC_BITS);
				end
				if (alu_done) begin
					state_d = k_q ? hcf_pkg::ST_SQ :
						(axis2d ? hcf_pkg::ST_RAD_DIV : hcf_pkg::ST_RAD_ROOT);
				end
			end
			hcf_pkg::ST_SQ: begin
				alu_ctrl.op = (idx_q == 2'd0) ? hcf_pkg::ALU_MUL : hcf_pkg::ALU_MAC;
				opa = {96'd0, mag_sel};
				opb = {32'd0, mag_sel};
				if (alu_done && idx_q == 2'd2) begin
					state_d = hcf_pkg::ST_DIST;
				end
			end
			hcf_pkg::ST_DIST: begin
				alu_ctrl.op = hcf_pkg::ALU_SQRT;
				opa = tmp_q;
				if (alu_done) begin
					state_d = (box_ok && {1'b0, alu_res[31:0]} < rp && alu_res[31:0] != 32'd0) ?
						hcf_pkg::ST_PROD : hcf_pkg::ST_DONE;
				end
			end
			hcf_pkg::ST_PROD: begin
				opa = {96'd0, radius_q[0]};
				opb = {32'd0, radius_q[1]};
				if (alu_done) begin
					state_d = hcf_pkg::ST_RRED;
				end
			end
			hcf_pkg::ST_RRED: begin
				alu_ctrl.op = hcf_pkg::ALU_DIV;
				opa = tmp_q;
				opb = {31'd0, rp};
				if (alu_done) begin
					state_d = hcf_pkg::ST_RP;
				end
			end
			hcf_pkg::ST_RP: begin
				opa = tmp_q;
				opb = {31'd0, p};
				if (alu_done) begin
					state_d = hcf_pkg::ST_SROOT;
				end
			end
			hcf_pkg::ST_SROOT: begin
				alu_ctrl.op = hcf_pkg::ALU_SQRT;
				opa = tmp_q;
				if (alu_done) begin
					state_d = hcf_pkg::ST_SP;
				end
			end
			hcf_pkg::ST_SP: begin
				opa = tmp_q;
				opb = {31'd0, p};
				if (alu_done) begin
					state_d = hcf_pkg::ST_EM;
				end
			end
			hcf_pkg::ST_EM: begin
				opa = {80'd0, cfg.contact_modulus};
				opb = tmp_q[63:0];
				if (alu_done) begin
					state_d = (q_big >= M_LIMIT) ? hcf_pkg::ST_UNIT : hcf_pkg::ST_DIV3;
				end
			end
			hcf_pkg::ST_DIV3: begin
				opa = tmp_q;
				opb = THIRD_RECIP;
				if (alu_done) begin
					state_d = hcf_pkg::ST_UNIT;
				end
			end
			hcf_pkg::ST_UNIT: begin
				alu_ctrl.op = hcf_pkg::ALU_DIV;
				opa = {96'd0, mag_sel} << 32;
				opb = {32'd0, r_q};
				if (alu_done) begin
					state_d = hcf_pkg::ST_FORCE;
				end
			end
			hcf_pkg::ST_FORCE: begin
				opa = {65'd0, m_q};
				opb = tmp_q[63:0];
				if (alu_done) begin
					state_d = last_axis ? hcf_pkg::ST_DONE : hcf_pkg::ST_UNIT;
				end
			end
			hcf_pkg::ST_DONE: begin
				if (can_out) begin
					state_d = hcf_pkg::ST_IDLE;
				end
			end
			default: state_d = hcf_pkg::ST_IDLE;
		endcase
		if (state_q != hcf_pkg::ST_IDLE && state_q != hcf_pkg::ST_DONE && !launch_q) begin
			alu_ctrl.start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q    <= 1'b0;
			k_q         <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				tot_q[i] <= '0;
			end
		end else begin
			if (alu_ctrl.start) begin
				launch_q <= 1'b1;
			end else if (alu_done) begin
				launch_q <= 1'b0;
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				hcf_pkg::ST_IDLE: begin
					if (accept) begin
						k_q <= 1'b0;
						if (pair.data.first_of_step) begin
							for (int i = 0; i < 3; i++) begin
								tot_q[i] <= '0;
							end
						end
					end
				end
				hcf_pkg::ST_RAD_ROOT: begin
					if (alu_done) begin
						k_q <= 1'b1;
					end
				end
				hcf_pkg::ST_SQ: begin
					if (alu_done) begin
						idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
					end
				end
				hcf_pkg::ST_FORCE: begin
					if (alu_done) begin
						idx_q <= last_axis ? 2'd0 : idx_q + 2'd1;
					end
				end
				hcf_pkg::ST_DONE: begin
					if (can_out) begin
						out_valid_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							tot_q[i] <= tot_n[i];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			hcf_pkg::ST_IDLE: begin
				if (accept) begin
					mag_q[0]  <= abs32(pair.data.offset_x);
					mag_q[1]  <= abs32(pair.data.offset_y);
					mag_q[2]  <= two_d ? 32'd0 : abs32(pair.data.offset_z);
					neg_q[0]  <= pair.data.offset_x[31];
					neg_q[1]  <= pair.data.offset_y[31];
					neg_q[2]  <= pair.data.offset_z[31] && !two_d;
					vol_q[0]  <= pair.data.vol_a;
					vol_q[1]  <= pair.data.vol_b;
					rad_q[0]  <= (pair.data.radial_a == 31'd0) ? 31'd1 : pair.data.radial_a;
					rad_q[1]  <= (pair.data.radial_b == 31'd0) ? 31'd1 : pair.data.radial_b;
					contact_q <= 1'b0;
					for (int i = 0; i < 3; i++) begin
						f_q[i] <= '0;
					end
				end
			end
			hcf_pkg::ST_RAD_ROOT: begin
				if (alu_done) begin
					radius_q[k_q] <= (|alu_res[63:33]) ? 32'hFFFF_FFFF : alu_res[32:1];
				end
			end
			hcf_pkg::ST_DIST: begin
				if (alu_done) begin
					r_q <= alu_res[31:0];
				end
			end
			hcf_pkg::ST_SP: begin
				if (alu_done) begin
					tmp_q <= {64'd0, m1_wide[63:0]};
				end
			end
			hcf_pkg::ST_EM: begin
				if (alu_done) begin
					tmp_q <= q_big;
					m_q   <= MAX63;
				end
			end
			hcf_pkg::ST_DIV3: begin
				if (alu_done) begin
					m_q <= alu_res[127:65];
				end
			end
			hcf_pkg::ST_FORCE: begin
				if (alu_done) begin
					f_q[idx_q] <= neg_q[idx_q] ? -$signed({1'b0, fm}) : $signed({1'b0, fm});
					if (fm != 63'd0) begin
						contact_q <= 1'b1;
					end
				end
			end
			hcf_pkg::ST_DONE: begin
				if (can_out) begin
					out_q.in_contact <= contact_q;
					out_q.force_x    <= f_q[0];
					out_q.force_y    <= f_q[1];
					out_q.force_z    <= f_q[2];
					out_q.sum_x      <= tot_n[0];
					out_q.sum_y      <= tot_n[1];
					out_q.sum_z      <= tot_n[2];
				end
			end
			default: begin
				if (alu_done) begin
					tmp_q <= alu_res;
				end
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_force_without_contact: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.in_contact |->
			result.data.force_x == 64'sd0 && result.data.force_y == 64'sd0 &&
			result.data.force_z == 64'sd0)
		else $error("force reported on a pair without contact");
	a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		pair.ready |-> !launch_q && !alu_ctrl.start)
		else $error("shared unit busy while waiting for a pair");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == hcf_pkg::ST_DONE))
		else $error("result raised outside the final step");
`endif
endmodule

### tb/hcf_contact_checker.sv
// ----------------------------------------------------------------------------
// Hertz contact force checker
// Watches the pair and result channels and the register port, predicts each
// result from the pair and the current settings, and compares field by field.
// ----------------------------------------------------------------------------
module hcf_contact_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pair_valid,
	input  logic                          pair_ready,
	input  hcf_pkg::hcf_pair_t            pair_data,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  hcf_pkg::hcf_result_t          result_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [hcf_pkg::APB_AW-1:0]    paddr,
	input  logic [hcf_pkg::APB_DW-1:0]    pwdata,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam logic signed [63:0] I64_MAX = 64'sh7FFFFFFFFFFFFFFF;
	localparam logic signed [63:0] I64_MIN = 64'sh8000000000000000;

	hcf_pkg::hcf_cfg_t    cfg;
	logic signed [63:0]   tot [3];
	hcf_pkg::hcf_result_t expected_q [$];

	function automatic logic [63:0] int_sqrt(logic [127:0] n);
		logic [63:0] res;
		logic [63:0] y;
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			y = res | (64'd1 << b);
			if ({64'd0, y} * {64'd0, y} <= n) res = y;
		end
		return res;
	endfunction

	function automatic logic [63:0] int_cbrt(logic [127:0] n);
		logic [63:0] res;
		logic [63:0] y;
		logic [63:0] y2;
		res = '0;
		for (int b = 31; b >= 0; b--) begin
			y = res | (64'd1 << b);
			y2 = y * y;
			if ({64'd0, y2} * {64'd0, y} <= n) res = y;
		end
		return res;
	endfunction

	function automatic logic [63:0] particle_radius(logic [31:0] vol, logic [30:0] radial,
			logic two_d);
		logic [63:0] root;
		logic [63:0] rad;
		logic [63:0] q;
		if (two_d && cfg.axisymmetric_mode) begin
			rad = (radial == 31'd0) ? 64'd1 : {33'd0, radial};
			q = ({32'd0, vol} << FB) / rad;
			root = int_sqrt({64'd0, q} << FB);
		end else if (two_d) begin
			root = int_sqrt({96'd0, vol} << FB);
		end else begin
			root = int_cbrt({96'd0, vol} << (2 * FB));
		end
		root = root >> 1;
		return (root > 64'hFFFFFFFF) ? 64'hFFFFFFFF : root;
	endfunction

	function automatic logic [63:0] sat_pos(logic [127:0] x);
		return (x > 128'h7FFFFFFFFFFFFFFF) ? 64'h7FFFFFFFFFFFFFFF : x[63:0];
	endfunction

	function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sd9223372036854775807) return I64_MAX;
		if (s < -65'sd9223372036854775808) return I64_MIN;
		return s[63:0];
	endfunction

	function automatic hcf_pkg::hcf_result_t predict_contact(hcf_pkg::hcf_pair_t pr);
		hcf_pkg::hcf_result_t res;
		logic signed [63:0] d [3];
		logic signed [63:0] f [3];
		logic [63:0] mag [3];
		logic [63:0] r0, r1, rp, sq, sep, pen, rred, s, m, u, fm;
		logic [127:0] prod;
		logic two_d, accept, contact;
		int nd;
		two_d = (cfg.dimension_mode == 2'd2);
		nd = two_d ? 2 : 3;
		accept = 1'b1;
		contact = 1'b0;
		d[0] = 64'($signed(pr.offset_x));
		d[1] = 64'($signed(pr.offset_y));
		d[2] = two_d ? 64'sd0 : 64'($signed(pr.offset_z));
		for (int i = 0; i < 3; i++) begin
			f[i] = 0;
			mag[i] = d[i] < 0 ? -d[i] : d[i];
		end
		if (pr.first_of_step) begin
			for (int i = 0; i < 3; i++) tot[i] = 0;
		end
		r0 = particle_radius(pr.vol_a, pr.radial_a, two_d);
		r1 = particle_radius(pr.vol_b, pr.radial_b, two_d);
		rp = r0 + r1;
		for (int i = 0; i < nd; i++)
			if (mag[i] > {33'd0, cfg.screen_distance} || mag[i] > rp) accept = 1'b0;
		sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		sep = int_sqrt({64'd0, sq});
		if (sep >= rp || sep == 0) accept = 1'b0;
		if (accept) begin
			pen = rp - sep;
			rred = (r0 * r1) / rp;
			s = int_sqrt({64'd0, rred * pen});
			prod = ({64'd0, s} * {64'd0, pen}) >> FB;
			prod = {80'd0, cfg.contact_modulus} * {64'd0, prod[63:0]};
			prod = prod << 2;
			prod = prod << (32 - 2 * FB);
			m = sat_pos(prod / 3);
			for (int i = 0; i < nd; i++) begin
				u = (mag[i] << 32) / sep;
				fm = sat_pos(({64'd0, m} * {64'd0, u}) >> 32);
				f[i] = d[i] < 0 ? -$signed(fm) : $signed(fm);
				if (fm != 0) contact = 1'b1;
			end
			if (contact) begin
				for (int i = 0; i < 3; i++) tot[i] = add_sat(tot[i], f[i]);
			end
		end
		res.in_contact = contact;
		res.force_x = f[0];
		res.force_y = f[1];
		res.force_z = f[2];
		res.sum_x = tot[0];
		res.sum_y = tot[1];
		res.sum_z = tot[2];
		return res;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("[%0t] mismatch in %s: got %h, expected %h", $realtime, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		hcf_pkg::hcf_result_t want;
		if (!arst_n) begin
			cfg = '{hcf_pkg::RST_DIMENSION, hcf_pkg::RST_AXISYM, hcf_pkg::RST_MODULUS,
				hcf_pkg::RST_SCREEN};
			for (int i = 0; i < 3; i++) tot[i] = 0;
			expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[hcf_pkg::APB_AW-1:3])
					hcf_pkg::REG_DIMENSION: cfg.dimension_mode = pwdata[1:0];
					hcf_pkg::REG_AXISYM:    cfg.axisymmetric_mode = pwdata[0];
					hcf_pkg::REG_MODULUS:   cfg.contact_modulus = pwdata[47:0];
					hcf_pkg::REG_SCREEN:    cfg.screen_distance = pwdata[30:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected transaction", 64'(result_data.in_contact),
						64'd0);
				end else begin
					want = expected_q.pop_front();
					if (result_data.in_contact !== want.in_contact)
						report_mismatch("in_contact", 64'(result_data.in_contact),
							64'(want.in_contact));
					if (result_data.force_x !== want.force_x)
						report_mismatch("force_x", result_data.force_x, want.force_x);
					if (result_data.force_y !== want.force_y)
						report_mismatch("force_y", result_data.force_y, want.force_y);
					if (result_data.force_z !== want.force_z)
						report_mismatch("force_z", result_data.force_z, want.force_z);
					if (result_data.sum_x !== want.sum_x)
						report_mismatch("sum_x", result_data.sum_x, want.sum_x);
					if (result_data.sum_y !== want.sum_y)
						report_mismatch("sum_y", result_data.sum_y, want.sum_y);
					if (result_data.sum_z !== want.sum_z)
						report_mismatch("sum_z", result_data.sum_z, want.sum_z);
				end
			end
			if (pair_valid && pair_ready) expected_q.push_back(predict_contact(pair_data));
			pending = expected_q.size();
		end
	end
endmodule

### tb/tb_hertz_contact_force_unit.sv
// ----------------------------------------------------------------------------
// Hertz contact force unit testbench
// Drives directed and random particle pairs through several register settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_hertz_contact_force_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [hcf_pkg::APB_AW-1:0] paddr;
	logic [hcf_pkg::APB_DW-1:0] pwdata;
	logic [hcf_pkg::APB_DW-1:0] prdata;
	logic                       pready;
	int                         errors;
	int                         pending;
	int                         idle_cycles;
	logic [1:0]                 dim_now;

	hcf_pair_if   pair ();
	hcf_result_if result ();

	hertz_contact_force_unit uut (
		.clk(clk), .arst_n(arst_n), .pair(pair.sink), .result(result.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	hcf_contact_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair.valid), .pair_ready(pair.ready), .pair_data(pair.data),
		.result_valid(result.valid), .result_ready(result.ready),
		.result_data(result.data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 40) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 300);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == hcf_pkg::REG_DIMENSION) dim_now = value[1:0];
	endtask

	task automatic wait_drained();
		pair.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (1400) @(posedge clk);
	endtask

	task automatic send_pair(hcf_pkg::hcf_pair_t pr);
		int g;
		g = gap_len();
		if (g > 0) begin
			pair.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pair.valid <= 1'b1;
		pair.data <= pr;
		@(posedge clk);
		while (!pair.ready) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			2: return 32'h7FFFFFFF;
			3: return 32'h80000000;
			default: return $urandom();
		endcase
	endfunction

	function automatic hcf_pkg::hcf_pair_t make_pair(logic well_formed);
		hcf_pkg::hcf_pair_t pr;
		logic [31:0] va, vb, span;
		int sh;
		pr.first_of_step = ($urandom_range(0, 9) == 0);
		pr.radial_a = 31'($urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(0, 300000));
		pr.radial_b = 31'($urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(0, 300000));
		if (!well_formed) begin
			pr.offset_x = rand_word();
			pr.offset_y = rand_word();
			pr.offset_z = rand_word();
			pr.vol_a = rand_word();
			pr.vol_b = rand_word();
			pr.radial_a = 31'(rand_word());
			pr.radial_b = 31'(rand_word());
			return pr;
		end
		sh = $urandom_range(8, 28);
		va = $urandom() >> (32 - sh);
		vb = $urandom() >> (32 - sh);
		pr.vol_a = va;
		pr.vol_b = vb;
		span = (dim_now == 2'd2) ? 32'd1 << (sh / 2 + 8) : 32'd1 << ((sh + 32) / 3);
		pr.offset_x = $signed($urandom_range(0, span)) * ($urandom_range(0, 1) ? 1 : -1);
		pr.offset_y = $signed($urandom_range(0, span)) * ($urandom_range(0, 1) ? 1 : -1);
		pr.offset_z = $signed($urandom_range(0, span)) * ($urandom_range(0, 1) ? 1 : -1);
		return pr;
	endfunction

	task automatic directed_pairs();
		hcf_pkg::hcf_pair_t pr;
		pr = '{32'sd0, 32'sd0, 32'sd0, 32'd65536, 32'd65536, 31'd65536, 31'd65536, 1'b1};
		send_pair(pr);
		pr.offset_x = 32'sd20000;
		send_pair(pr);
		pr.offset_x = -32'sd20000;
		pr.offset_y = 32'sd10000;
		pr.offset_z = -32'sd5000;
		send_pair(pr);
		pr = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
			31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0};
		send_pair(pr);
		pr = '{32'sd1, 32'sd0, 32'sd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'd0, 31'd0, 1'b0};
		send_pair(pr);
		pr = '{-32'sd1, -32'sd1, -32'sd1, 32'd0, 32'd0, 31'd1, 31'd1, 1'b0};
		send_pair(pr);
		pr = '{32'sd30000, -32'sd30000, 32'sd30000, 32'd400000, 32'd1, 31'd1, 31'd1, 1'b0};
		send_pair(pr);
	endtask

	initial begin
		hcf_pkg::hcf_pair_t pr;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pair.valid = 1'b0;
		pair.data = '0;
		dim_now = hcf_pkg::RST_DIMENSION;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_pairs();
		wait_drained();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(hcf_pkg::REG_DIMENSION, 64'd2);
					write_reg(hcf_pkg::REG_AXISYM, 64'd0);
					write_reg(hcf_pkg::REG_MODULUS, 64'hFFFFFFFFFFFF);
					write_reg(hcf_pkg::REG_SCREEN, 64'h7FFFFFFF);
				end
				1: write_reg(hcf_pkg::REG_AXISYM, 64'd1);
				2: begin
					write_reg(hcf_pkg::REG_DIMENSION, 64'd3);
					write_reg(hcf_pkg::REG_MODULUS, 64'd0);
				end
				3: begin
					write_reg(hcf_pkg::REG_DIMENSION, 64'd1);
					write_reg(hcf_pkg::REG_MODULUS, 64'd65536 * 200);
					write_reg(hcf_pkg::REG_SCREEN, 64'd0);
				end
				4: write_reg(hcf_pkg::REG_SCREEN, 64'd1 << 20);
				5: begin
					write_reg(hcf_pkg::REG_DIMENSION, 64'd0);
					write_reg(hcf_pkg::REG_AXISYM, 64'd0);
					write_reg(hcf_pkg::REG_MODULUS, 64'hFFFFFFFFFFFF);
					write_reg(hcf_pkg::REG_SCREEN, 64'h7FFFFFFF);
				end
				6: begin
					write_reg(hcf_pkg::REG_DIMENSION, 64'd2);
					write_reg(hcf_pkg::REG_AXISYM, 64'd1);
					write_reg(hcf_pkg::REG_MODULUS, {32'd0, $urandom()});
				end
				default: begin
					write_reg(hcf_pkg::REG_DIMENSION, 64'd3);
					write_reg(hcf_pkg::REG_MODULUS, 64'd1);
				end
			endcase
			if (ph == 0) begin
				directed_pairs();
			end
			for (int n = 0; n < 50; n++) begin
				pr = make_pair($urandom_range(0, 9) < 8);
				send_pair(pr);
			end
			wait_drained();
		end
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int g;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			g = gap_len();
			if ($urandom_range(0, 2) == 0 && g > 0) begin
				result.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			result.ready <= 1'b1;
		end
	end

	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((pair.valid && pair.ready) || (result.valid && result.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end
endmodule
